[hw/rtl/brdq_pkg.sv]
// package for the byte range descriptor queue
// holds payload structs, action codes and sizes; no dependencies
package brdq_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_SUBRANGE = 3'd1,
        ACT_DROP = 3'd2,
        ACT_LIMIT = 3'd3,
        ACT_SKIP = 3'd4,
        ACT_FLUSH = 3'd5,
        ACT_SEND = 3'd6,
        ACT_NONE = 3'd7
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] buffer_id;
        logic [31:0] range_offset;
        logic [31:0] range_size;
        logic [31:0] byte_offset;
        logic [31:0] byte_count;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [31:0] bytes_done;
        logic        out_valid;
        logic [15:0] out_buffer_id;
        logic [31:0] out_offset;
        logic [31:0] out_size;
        logic        last;
        logic [31:0] total_bytes;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [15:0] buf_id;
        logic [31:0] start;
        logic [31:0] len;
    } t_desc;

    // per-cycle command from the sequencer to every cell
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_LEFT = 2'd1,
        SH_RIGHT = 2'd2
    } t_shift;

    typedef struct packed {
        t_shift      shift;
        logic [IDX_W-1:0] pos;
        logic        wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_desc       wr_desc;
    } t_ctl;
endpackage

[hw/rtl/brdq_cell.sv]
// one descriptor slot of the queue chain
// depends on brdq_pkg
module brdq_cell (
    input  logic                    i_clk,
    input  logic [brdq_pkg::IDX_W-1:0] i_index,
    input  brdq_pkg::t_ctl          i_ctl,
    input  brdq_pkg::t_desc         i_from_right,
    input  brdq_pkg::t_desc         i_from_left,
    output brdq_pkg::t_desc         o_desc
);
    brdq_pkg::t_desc r_desc;
    assign o_desc = r_desc;

    // direct write wins, else shift cells at or above pos
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_idx == i_index) begin
            r_desc <= i_ctl.wr_desc;
        end else if (i_index >= i_ctl.pos) begin
            unique case (i_ctl.shift)
                brdq_pkg::SH_LEFT:  r_desc <= i_from_right;
                brdq_pkg::SH_RIGHT: r_desc <= i_from_left;
                default: ;
            endcase
        end
    end
endmodule

[hw/rtl/byte_range_descriptor_queue.sv]
// top level: sequencer driving a row of descriptor cells
// depends on brdq_pkg and brdq_cell
//
// One action is taken per start while busy is low. Append, sub-range, flush,
// unknown actions and a limit that cuts nothing go straight to the done state;
// drop front and limit total handle one entry per cycle; skip middle walks to
// the first and the last touched entry one per cycle and then closes the gap
// one slot per cycle. Send all reads the cells in order, one descriptor per
// cycle. Results appear for one cycle on o_result with o_result_valid and
// cannot be stalled.
module byte_range_descriptor_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  brdq_pkg::t_in    i_item,
    output logic             o_result_valid,
    output brdq_pkg::t_out   o_result,
    input  logic             i_cfg_we,
    input  logic [4:0]       i_cfg_data
);
    localparam int IW = brdq_pkg::IDX_W;
    localparam int CW = brdq_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DROP, S_LIMIT, S_SKIP_F, S_SKIP_L, S_SKIP_DO, S_SHIFT,
        S_SEND, S_DONE
    } t_state;

    t_state r_state;
    brdq_pkg::t_in r_in;
    logic [4:0] r_limit;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_total;
    logic [31:0] r_num, r_done;
    logic [32:0] r_rel;
    logic [IW-1:0] r_first, r_last, r_ptr;
    logic [CW-1:0] r_shifts;
    logic r_status;
    brdq_pkg::t_out n_result;

    brdq_pkg::t_desc w_desc [brdq_pkg::MAX_ENTRIES];
    brdq_pkg::t_ctl  w_ctl;
    brdq_pkg::t_desc w_zero;
    assign w_zero = '0;

    // chain of cells
    genvar g;
    generate
        for (g = 0; g < brdq_pkg::MAX_ENTRIES; g++) begin : g_cell
            brdq_cell u_cell (
                .i_clk(i_clk), .i_index(IW'(g)), .i_ctl(w_ctl),
                .i_from_right(g == brdq_pkg::MAX_ENTRIES-1 ? w_zero
                              : w_desc[(g+1) % brdq_pkg::MAX_ENTRIES]),
                .i_from_left(g == 0 ? w_zero
                             : w_desc[(g+brdq_pkg::MAX_ENTRIES-1) % brdq_pkg::MAX_ENTRIES]),
                .o_desc(w_desc[g])
            );
        end
    endgenerate

    logic [CW-1:0] w_eff;
    assign w_eff = (r_limit > 5'(brdq_pkg::MAX_ENTRIES)) ? CW'(brdq_pkg::MAX_ENTRIES)
                                                          : CW'(r_limit);
    logic [IW-1:0] w_tail;
    assign w_tail = IW'(r_cnt - CW'(1));
    brdq_pkg::t_desc w_head, w_back, w_fd, w_ld;
    assign w_head = w_desc[0];
    assign w_back = w_desc[w_tail];
    assign w_fd = w_desc[r_first];
    assign w_ld = w_desc[r_last];

    assign busy = (r_state != S_IDLE);

    // cell control for the current state
    always_comb begin
        w_ctl = '0;
        w_ctl.shift = brdq_pkg::SH_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_item.action == brdq_pkg::ACT_APPEND
                        || i_item.action == brdq_pkg::ACT_SUBRANGE)
                        && r_cnt < w_eff && i_item.range_size != 32'd0) begin
                    w_ctl.wr_en = 1'b1;
                    w_ctl.wr_idx = IW'(r_cnt);
                    w_ctl.wr_desc.buf_id = i_item.buffer_id;
                    if (i_item.action == brdq_pkg::ACT_APPEND) begin
                        w_ctl.wr_desc.start = i_item.range_offset;
                        w_ctl.wr_desc.len = i_item.range_size;
                    end else begin
                        w_ctl.wr_desc.start = i_item.range_offset + i_item.byte_offset;
                        w_ctl.wr_desc.len = i_item.byte_count;
                    end
                end
            end
            S_DROP: begin
                if (r_cnt != '0 && r_num != 32'd0) begin
                    if (w_head.len > r_num) begin
                        w_ctl.wr_en = 1'b1;
                        w_ctl.wr_desc = w_head;
                        w_ctl.wr_desc.start = w_head.start + r_num;
                        w_ctl.wr_desc.len = w_head.len - r_num;
                    end else begin
                        w_ctl.shift = brdq_pkg::SH_LEFT;
                    end
                end
            end
            S_LIMIT: begin
                if (r_cnt != '0 && r_num != 32'd0 && w_back.len > r_num) begin
                    w_ctl.wr_en = 1'b1;
                    w_ctl.wr_idx = w_tail;
                    w_ctl.wr_desc = w_back;
                    w_ctl.wr_desc.len = w_back.len - r_num;
                end
            end
            S_SKIP_DO: begin
                if (r_first == r_last) begin
                    // open a slot after first; copy of first lands there
                    if (r_cnt < w_eff) begin
                        w_ctl.shift = brdq_pkg::SH_RIGHT;
                        w_ctl.pos = r_first + IW'(1);
                    end
                end else begin
                    w_ctl.wr_en = 1'b1;
                    w_ctl.wr_idx = r_last;
                    w_ctl.wr_desc = w_ld;
                    w_ctl.wr_desc.start = w_ld.start + r_rel[31:0];
                    w_ctl.wr_desc.len = w_ld.len - r_rel[31:0];
                end
            end
            S_SHIFT: begin
                if (r_shifts != '0) begin
                    w_ctl.shift = brdq_pkg::SH_LEFT;
                    w_ctl.pos = r_first + IW'(1);
                end else if (r_rel != '0) begin
                    // far half of a split entry starts after the skipped bytes
                    w_ctl.wr_en = 1'b1;
                    w_ctl.wr_idx = r_last;
                    w_ctl.wr_desc = w_ld;
                    w_ctl.wr_desc.start = w_ld.start + r_rel[31:0];
                    w_ctl.wr_desc.len = w_ld.len - r_rel[31:0];
                end else begin
                    // near part keeps only the bytes before the skip
                    w_ctl.wr_en = 1'b1;
                    w_ctl.wr_idx = r_first;
                    w_ctl.wr_desc = w_fd;
                    w_ctl.wr_desc.len = r_num;
                end
            end
            default: ;
        endcase
    end

    // result beat for send and done states
    always_comb begin
        n_result = '0;
        if (r_state == S_SEND) begin
            n_result.out_valid = 1'b1;
            n_result.out_buffer_id = w_desc[r_ptr].buf_id;
            n_result.out_offset = w_desc[r_ptr].start;
            n_result.out_size = w_desc[r_ptr].len;
            n_result.last = (CW'(r_ptr) + CW'(1) == r_shifts);
        end else begin
            n_result.status = r_status;
            n_result.bytes_done = (r_in.action == brdq_pkg::ACT_DROP) ? r_done : 32'd0;
            n_result.last = 1'b1;
            n_result.total_bytes = r_total;
            n_result.entry_count = 5'(r_cnt);
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_total <= '0;
            r_limit <= 5'd16;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (r_state == S_SEND) || (r_state == S_DONE);
            if (i_cfg_we) r_limit <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in <= i_item;
                        r_done <= '0;
                        r_status <= (i_item.action == brdq_pkg::ACT_APPEND
                                     || i_item.action == brdq_pkg::ACT_SUBRANGE)
                                    && r_cnt >= w_eff;
                        unique case (i_item.action)
                            brdq_pkg::ACT_APPEND, brdq_pkg::ACT_SUBRANGE: begin
                                r_state <= S_DONE;
                                if (r_cnt < w_eff && i_item.range_size != 32'd0) begin
                                    r_cnt <= r_cnt + CW'(1);
                                    r_total <= r_total + (i_item.action == brdq_pkg::ACT_APPEND
                                        ? i_item.range_size : i_item.byte_count);
                                end
                            end
                            brdq_pkg::ACT_DROP: begin
                                r_num <= i_item.byte_count;
                                r_state <= S_DROP;
                            end
                            brdq_pkg::ACT_LIMIT: begin
                                if (i_item.byte_count < r_total) begin
                                    r_num <= r_total - i_item.byte_count;
                                    r_total <= i_item.byte_count;
                                    r_state <= S_LIMIT;
                                end else r_state <= S_DONE;
                            end
                            brdq_pkg::ACT_SKIP: begin
                                if (i_item.byte_count == 32'd0) r_state <= S_DONE;
                                else if (i_item.byte_offset == 32'd0) begin
                                    r_num <= i_item.byte_count;
                                    r_state <= S_DROP;
                                end else if ({1'b0, i_item.byte_offset}
                                             + {1'b0, i_item.byte_count}
                                             >= {1'b0, r_total}) begin
                                    if (i_item.byte_offset < r_total) begin
                                        r_num <= r_total - i_item.byte_offset;
                                        r_total <= i_item.byte_offset;
                                        r_state <= S_LIMIT;
                                    end else r_state <= S_DONE;
                                end else begin
                                    r_num <= i_item.byte_offset;
                                    r_first <= '0;
                                    r_state <= S_SKIP_F;
                                end
                            end
                            brdq_pkg::ACT_FLUSH: begin
                                r_cnt <= '0;
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                            brdq_pkg::ACT_SEND: begin
                                r_ptr <= '0;
                                r_shifts <= r_cnt;
                                r_cnt <= '0;
                                r_total <= '0;
                                r_state <= (r_cnt != '0) ? S_SEND : S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DROP: begin
                    if (r_cnt != '0 && r_num != 32'd0) begin
                        if (w_head.len > r_num) begin
                            r_done <= r_done + r_num;
                            r_num <= '0;
                        end else begin
                            r_done <= r_done + w_head.len;
                            r_num <= r_num - w_head.len;
                            r_cnt <= r_cnt - CW'(1);
                        end
                    end else begin
                        r_total <= r_total - r_done;
                        if (r_in.action == brdq_pkg::ACT_SKIP) r_done <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_LIMIT: begin
                    if (r_cnt != '0 && r_num != 32'd0) begin
                        if (w_back.len > r_num) r_num <= '0;
                        else begin
                            r_num <= r_num - w_back.len;
                            r_cnt <= r_cnt - CW'(1);
                        end
                    end else r_state <= S_DONE;
                end
                S_SKIP_F: begin
                    if (CW'(r_first) < r_cnt && r_num > w_fd.len) begin
                        r_num <= r_num - w_fd.len;
                        if (CW'(r_first) + CW'(1) < r_cnt) r_first <= r_first + IW'(1);
                        else r_state <= S_DONE;
                    end else if (CW'(r_first) >= r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_last <= r_first;
                        r_rel <= {1'b0, r_in.byte_count} + {1'b0, r_num};
                        r_state <= S_SKIP_L;
                    end
                end
                S_SKIP_L: begin
                    if (CW'(r_last) < r_cnt && r_rel >= {1'b0, w_ld.len}) begin
                        r_rel <= r_rel - {1'b0, w_ld.len};
                        if (CW'(r_last) + CW'(1) < r_cnt) r_last <= r_last + IW'(1);
                        else r_state <= S_DONE;
                    end else r_state <= S_SKIP_DO;
                end
                S_SKIP_DO: begin
                    if (r_first == r_last) begin
                        if (r_cnt >= w_eff) begin
                            r_status <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                            r_last <= r_first + IW'(1);
                            r_shifts <= '0;
                            r_total <= r_total - r_in.byte_count;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_shifts <= CW'(r_last - r_first - IW'(1));
                        r_cnt <= r_cnt - CW'(r_last - r_first - IW'(1));
                        r_rel <= '0;
                        r_total <= r_total - r_in.byte_count;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_shifts != '0) r_shifts <= r_shifts - CW'(1);
                    else if (r_rel != '0) r_rel <= '0;
                    else r_state <= S_DONE;
                end
                S_SEND: begin
                    o_result <= n_result;
                    if (CW'(r_ptr) + CW'(1) == r_shifts) r_state <= S_IDLE;
                    else r_ptr <= r_ptr + IW'(1);
                end
                default: begin
                    o_result <= n_result;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(brdq_pkg::MAX_ENTRIES)) else $error("count overflow");
    a_busy_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last |-> !busy) else $error("busy after last");
    a_idle_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_IDLE |-> !o_result_valid) else $error("stray result");
endmodule

[tb/tb.sv]
// testbench for byte_range_descriptor_queue: directed and random actions
// checked against an in-bench model of the descriptor list; depends on brdq_pkg
`timescale 1ns / 1ps

module tb;
    import brdq_pkg::*;

    // expected result store and descriptor list model
    class brdq_scoreboard;
        t_out        pending[$];
        logic [15:0] ent_buf[MAX_ENTRIES];
        logic [31:0] ent_start[MAX_ENTRIES];
        logic [31:0] ent_len[MAX_ENTRIES];
        int unsigned n_held;
        logic [31:0] n_bytes;
        logic [4:0]  lim;
        int          errors;

        function void clear();
            n_held = 0;
            n_bytes = 0;
            lim = 16;
            errors = 0;
        endfunction

        function int unsigned eff_lim();
            return (lim > MAX_ENTRIES) ? MAX_ENTRIES : lim;
        endfunction

        function void move_ent(int unsigned to, int unsigned from);
            ent_buf[to] = ent_buf[from];
            ent_start[to] = ent_start[from];
            ent_len[to] = ent_len[from];
        endfunction

        function logic [31:0] drop_head(logic [31:0] num);
            logic [31:0] done;
            done = 0;
            while (n_held != 0 && num != 0) begin
                if (ent_len[0] > num) begin
                    ent_start[0] += num;
                    ent_len[0] -= num;
                    done += num;
                    num = 0;
                end else begin
                    num -= ent_len[0];
                    done += ent_len[0];
                    n_held--;
                    for (int unsigned i = 0; i < n_held; i++) move_ent(i, i + 1);
                end
            end
            n_bytes -= done;
            return done;
        endfunction

        function void trim_total(logic [31:0] num);
            logic [31:0] cut;
            if (num >= n_bytes) return;
            cut = n_bytes - num;
            n_bytes = num;
            while (n_held != 0 && cut != 0) begin
                if (ent_len[n_held-1] > cut) begin
                    ent_len[n_held-1] -= cut;
                    cut = 0;
                end else begin
                    cut -= ent_len[n_held-1];
                    n_held--;
                end
            end
        endfunction

        function logic cut_middle(logic [31:0] off, logic [31:0] num);
            int unsigned first, lst;
            logic [63:0] rel;
            logic [31:0] dummy;
            if (num == 0) return 0;
            if (off == 0) begin
                dummy = drop_head(num);
                return 0;
            end
            if ({32'd0, off} + {32'd0, num} >= {32'd0, n_bytes}) begin
                trim_total(off);
                return 0;
            end
            first = 0;
            while (first < n_held && off > ent_len[first]) begin
                off -= ent_len[first];
                first++;
            end
            if (first >= n_held) return 0;
            lst = first;
            rel = {32'd0, num} + {32'd0, off};
            while (lst < n_held && rel >= {32'd0, ent_len[lst]}) begin
                rel -= ent_len[lst];
                lst++;
            end
            if (lst >= n_held) return 0;
            if (first == lst) begin
                // split one entry in two
                if (n_held >= eff_lim()) return 1;
                for (int unsigned i = n_held; i > lst; i--) move_ent(i, i - 1);
                n_held++;
                ent_len[first] = off;
                ent_len[lst+1] -= rel[31:0];
                ent_start[lst+1] += rel[31:0];
            end else begin
                ent_len[first] = off;
                ent_len[lst] -= rel[31:0];
                ent_start[lst] += rel[31:0];
                if (lst != first + 1) begin
                    for (int unsigned i = lst; i < n_held; i++)
                        move_ent(first + 1 + i - lst, i);
                    n_held -= lst - first - 1;
                end
            end
            n_bytes -= num;
            return 0;
        endfunction

        function void push(logic st, logic [31:0] done, logic v, logic [15:0] b,
                           logic [31:0] o, logic [31:0] s, logic l);
            t_out r;
            r.status = st;
            r.bytes_done = done;
            r.out_valid = v;
            r.out_buffer_id = b;
            r.out_offset = o;
            r.out_size = s;
            r.last = l;
            r.total_bytes = n_bytes;
            r.entry_count = n_held[4:0];
            pending.push_back(r);
        endfunction

        // note an accepted command beat
        function void note_cmd(t_in c);
            logic st;
            logic [31:0] done;
            int unsigned n;
            st = 0;
            done = 0;
            case (t_action'(c.action))
                ACT_APPEND, ACT_SUBRANGE: begin
                    if (n_held >= eff_lim()) st = 1;
                    else if (c.range_size != 0) begin
                        ent_buf[n_held] = c.buffer_id;
                        if (t_action'(c.action) == ACT_APPEND) begin
                            ent_start[n_held] = c.range_offset;
                            ent_len[n_held] = c.range_size;
                            n_bytes += c.range_size;
                        end else begin
                            ent_start[n_held] = c.range_offset + c.byte_offset;
                            ent_len[n_held] = c.byte_count;
                            n_bytes += c.byte_count;
                        end
                        n_held++;
                    end
                end
                ACT_DROP: done = drop_head(c.byte_count);
                ACT_LIMIT: trim_total(c.byte_count);
                ACT_SKIP: st = cut_middle(c.byte_offset, c.byte_count);
                ACT_FLUSH: begin
                    n_held = 0;
                    n_bytes = 0;
                end
                ACT_SEND: begin
                    n = n_held;
                    n_held = 0;
                    n_bytes = 0;
                    for (int unsigned i = 0; i < n; i++)
                        push(0, 0, 1, ent_buf[i], ent_start[i], ent_len[i], i + 1 == n);
                    if (n != 0) return;
                end
                default: ;
            endcase
            push(st, done, 0, 0, 0, 0, 1);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(t_out a);
            t_out e;
            if (pending.size() == 0) begin
                $error("unexpected result beat %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0h got %0h", e.status, a.status); errors++;
            end
            if (a.bytes_done !== e.bytes_done) begin
                $error("bytes_done exp %0h got %0h", e.bytes_done, a.bytes_done); errors++;
            end
            if (a.out_valid !== e.out_valid) begin
                $error("out_valid exp %0h got %0h", e.out_valid, a.out_valid); errors++;
            end
            if (a.out_buffer_id !== e.out_buffer_id) begin
                $error("out_buffer_id exp %0h got %0h", e.out_buffer_id, a.out_buffer_id);
                errors++;
            end
            if (a.out_offset !== e.out_offset) begin
                $error("out_offset exp %0h got %0h", e.out_offset, a.out_offset); errors++;
            end
            if (a.out_size !== e.out_size) begin
                $error("out_size exp %0h got %0h", e.out_size, a.out_size); errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %0h got %0h", e.last, a.last); errors++;
            end
            if (a.total_bytes !== e.total_bytes) begin
                $error("total_bytes exp %0h got %0h", e.total_bytes, a.total_bytes);
                errors++;
            end
            if (a.entry_count !== e.entry_count) begin
                $error("entry_count exp %0h got %0h", e.entry_count, a.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in        i_item;
    logic       o_result_valid;
    t_out       o_result;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    brdq_scoreboard sb;
    int         burst_left;

    byte_range_descriptor_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    // send one command beat, with bursty gaps before it; start stays high
    // until the next call or drain takes it over at the same falling edge
    task automatic send_cmd(t_in c);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_item <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (2 * MAX_ENTRIES + 8) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.lim = v;
    endtask

    function automatic t_in mk(t_action a, logic [15:0] b, logic [31:0] ro,
                               logic [31:0] rs, logic [31:0] bo, logic [31:0] bc);
        t_in c;
        c.action = a;
        c.buffer_id = b;
        c.range_offset = ro;
        c.range_size = rs;
        c.byte_offset = bo;
        c.byte_count = bc;
        return c;
    endfunction

    // random command, mostly sized to keep entries and offsets meaningful
    function automatic t_in rand_cmd();
        t_in c;
        int unsigned pick;
        c.buffer_id = 16'($urandom);
        c.range_offset = $urandom;
        c.range_size = $urandom;
        c.byte_offset = $urandom;
        c.byte_count = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) c.action = ACT_APPEND;
        else if (pick < 50) c.action = ACT_SUBRANGE;
        else if (pick < 60) c.action = ACT_DROP;
        else if (pick < 67) c.action = ACT_LIMIT;
        else if (pick < 85) c.action = ACT_SKIP;
        else if (pick < 89) c.action = ACT_FLUSH;
        else if (pick < 97) c.action = ACT_SEND;
        else c.action = ACT_NONE;
        if ($urandom_range(0, 9) != 0) begin
            c.range_size = $urandom_range(0, 40);
            c.byte_count = $urandom_range(0, 60);
            c.byte_offset = $urandom_range(0, sb.n_bytes + 4);
        end
        return c;
    endfunction

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb = new();
        sb.clear();
        burst_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = 5'd16;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, every action, special cases
        send_cmd(mk(ACT_SEND, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'hFFFF, 32'hFFFFFFFF, 32'd0, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'h1234, 32'd100, 32'd10, 0, 0));
        send_cmd(mk(ACT_SUBRANGE, 16'h0001, 32'hFFFFFFF0, 32'd5, 32'h20, 32'd7));
        send_cmd(mk(ACT_SUBRANGE, 16'h0002, 32'd0, 32'd0, 32'd3, 32'd7));
        send_cmd(mk(ACT_SEND, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd1, 32'd0, 32'd20, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd2, 32'd50, 32'd20, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd3, 32'd90, 32'd20, 0, 0));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd5, 32'd3));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd10, 32'd25));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd0, 32'd4));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd7, 32'd0));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd30, 32'hFFFFFFFF));
        send_cmd(mk(ACT_DROP, 0, 0, 0, 0, 32'd6));
        send_cmd(mk(ACT_LIMIT, 0, 0, 0, 0, 32'd9));
        send_cmd(mk(ACT_DROP, 0, 0, 0, 0, 32'hFFFFFFFF));
        send_cmd(mk(ACT_NONE, 16'hFFFF, '1, '1, '1, '1));
        send_cmd(mk(ACT_APPEND, 16'd4, 32'd0, 32'hFFFFFFF0, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd5, 32'd0, 32'h20, 0, 0));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd2, 32'd1));
        send_cmd(mk(ACT_FLUSH, 0, 0, 0, 0, 0));

        // full queue and split refused at limit
        write_limit(5'd2);
        send_cmd(mk(ACT_APPEND, 16'd6, 32'd0, 32'd10, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd7, 32'd0, 32'd10, 0, 0));
        send_cmd(mk(ACT_APPEND, 16'd8, 32'd0, 32'd0, 0, 0));
        send_cmd(mk(ACT_SKIP, 0, 0, 0, 32'd2, 32'd3));
        send_cmd(mk(ACT_SEND, 0, 0, 0, 0, 0));

        // random phases over several limits
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_limit(5'd16);
                1: write_limit(5'd1);
                2: write_limit(5'd0);
                3: write_limit(5'd31);
                default: write_limit(5'($urandom_range(3, 15)));
            endcase
            for (int k = 0; k < 30; k++) send_cmd(rand_cmd());
            if (ph == 2) drain();
        end
        send_cmd(mk(ACT_SEND, 0, 0, 0, 0, 0));

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
